// ----- hw/rtl/hhm_pkg.sv -----
// types and constants shared by the heartbeat health monitor modules
package hhm_pkg;

	localparam int NUM_SRC = 6;
	localparam int NUM_MGR = 3;

	typedef logic [2:0] hhm_cmd_t;
	localparam hhm_cmd_t CMD_ESTIMATOR  = 3'd0;
	localparam hhm_cmd_t CMD_AUTOPILOT  = 3'd1;
	localparam hhm_cmd_t CMD_EST_MGR    = 3'd2;
	localparam hhm_cmd_t CMD_CTRL_MGR   = 3'd3;
	localparam hhm_cmd_t CMD_TRAJ_MGR   = 3'd4;
	localparam hhm_cmd_t CMD_SAFETY     = 3'd5;
	localparam hhm_cmd_t CMD_QUERY      = 3'd6;

	typedef logic [2:0] hhm_code_t;
	localparam hhm_code_t CODE_OK           = 3'd0;
	localparam hhm_code_t CODE_MISSING      = 3'd1;
	localparam hhm_code_t CODE_INACTIVE     = 3'd2;
	localparam hhm_code_t CODE_UNHEALTHY    = 3'd3;
	localparam hhm_code_t CODE_STALE        = 3'd4;
	localparam hhm_code_t CODE_DISCONNECTED = 3'd5;
	localparam hhm_code_t CODE_FAILSAFE     = 3'd6;

	typedef logic [2:0] hhm_reg_t;
	localparam hhm_reg_t REG_EST_TIMEOUT  = 3'd0;
	localparam hhm_reg_t REG_AP_TIMEOUT   = 3'd1;
	localparam hhm_reg_t REG_MGR_TIMEOUT  = 3'd2;
	localparam hhm_reg_t REG_SAFE_TIMEOUT = 3'd3;
	localparam hhm_reg_t REG_REQ_SAFETY   = 3'd4;

	localparam int SRC_ESTIMATOR = 0;
	localparam int SRC_AUTOPILOT = 1;
	localparam int SRC_MGR_BASE  = 2;
	localparam int SRC_SAFETY    = 5;

	localparam int AP_CONNECTED = 0;
	localparam int AP_ARMED     = 1;
	localparam int AP_OFFBOARD  = 2;
	localparam int AP_FAILSAFE  = 3;

	localparam logic [7:0] SAFETY_CRITICAL = 8'd2;

	typedef struct packed {
		hhm_cmd_t    cmd;
		logic [31:0] now_ms;
		logic        active;
		logic        healthy;
		logic        connected;
		logic        armed;
		logic        offboard;
		logic        failsafe;
		logic [7:0]  nav_state;
		logic [7:0]  safety_level;
	} hhm_item_t;

	typedef struct packed {
		logic [15:0] est_timeout;
		logic [15:0] ap_timeout;
		logic [15:0] mgr_timeout;
		logic [15:0] safe_timeout;
		logic        req_safety;
	} hhm_cfg_t;

	typedef struct packed {
		logic [NUM_SRC-1:0] present;
		logic [NUM_MGR-1:0] mgr_active;
		logic [NUM_MGR-1:0] mgr_healthy;
		logic [3:0]         ap_flags;
		logic [7:0]         ap_nav;
		logic [7:0]         safe_level;
	} hhm_status_t;

	typedef struct packed {
		hhm_code_t   autopilot_code;
		hhm_code_t   estimator_code;
		hhm_code_t   estimation_mgr_code;
		hhm_code_t   control_mgr_code;
		hhm_code_t   trajectory_mgr_code;
		hhm_code_t   safety_code;
		logic        out_connected;
		logic        out_armed;
		logic        out_offboard;
		logic [7:0]  out_nav_state;
		logic        out_require_safety;
	} hhm_result_t;

endpackage

// ----- hw/rtl/hhm_state.sv -----
// per-source heartbeat state: presence, timestamps and last reported status
module hhm_state #(
	parameter int TIME_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   upd_en,
	input  hhm_pkg::hhm_item_t     item,
	output hhm_pkg::hhm_status_t   status,
	output logic [TIME_BITS-1:0]   stamp [hhm_pkg::NUM_SRC]
);
	import hhm_pkg::*;

	hhm_status_t          status_q;
	logic [TIME_BITS-1:0] stamp_q [NUM_SRC];
	logic [63:0]          now_w;
	logic                 is_update;
	logic [1:0]           mgr_idx;

	assign now_w     = {32'd0, item.now_ms};
	assign is_update = upd_en && (item.cmd <= CMD_SAFETY);
	assign mgr_idx   = 2'(item.cmd - CMD_EST_MGR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
		end else if (is_update) begin
			status_q.present[item.cmd] <= 1'b1;
			case (item.cmd) inside
				CMD_AUTOPILOT: begin
					status_q.ap_flags <= {item.failsafe, item.offboard, item.armed,
						item.connected};
					status_q.ap_nav   <= item.nav_state;
				end
				CMD_EST_MGR, CMD_CTRL_MGR, CMD_TRAJ_MGR: begin
					status_q.mgr_active[mgr_idx]  <= item.active;
					status_q.mgr_healthy[mgr_idx] <= item.healthy;
				end
				CMD_SAFETY: begin
					status_q.safe_level <= item.safety_level;
				end
				default: begin
				end
			endcase
		end
	end

	// timestamps are only read once the source is present
	always_ff @(posedge clk) begin
		if (is_update) begin
			stamp_q[item.cmd] <= now_w[TIME_BITS-1:0];
		end
	end

	assign status = status_q;
	assign stamp  = stamp_q;

	a_update_marks_present: assert property (@(posedge clk) disable iff (!arst_n)
		is_update |=> status_q.present[$past(item.cmd)])
		else $error("updated source not marked present");

endmodule

// ----- hw/rtl/hhm_eval.sv -----
// readiness ladders: missing, stale, then per-source status checks
module hhm_eval #(
	parameter int TIME_BITS = 32
) (
	input  logic [31:0]           now_ms,
	input  hhm_pkg::hhm_cfg_t     cfg,
	input  hhm_pkg::hhm_status_t  status,
	input  logic [TIME_BITS-1:0]  stamp [hhm_pkg::NUM_SRC],
	output hhm_pkg::hhm_result_t  result
);
	import hhm_pkg::*;

	logic [63:0]          now_w;
	logic [TIME_BITS-1:0] now_t;
	logic [15:0]          timeout [NUM_SRC];
	logic [TIME_BITS-1:0] limit [NUM_SRC];
	logic [NUM_SRC-1:0]   fresh;
	hhm_code_t            mgr_code [NUM_MGR];
	logic [63:0]          to_w [NUM_SRC];

	assign now_w = {32'd0, now_ms};
	assign now_t = now_w[TIME_BITS-1:0];

	always_comb begin
		timeout[SRC_ESTIMATOR] = cfg.est_timeout;
		timeout[SRC_AUTOPILOT] = cfg.ap_timeout;
		for (int m = 0; m < NUM_MGR; m++) begin
			timeout[SRC_MGR_BASE + m] = cfg.mgr_timeout;
		end
		timeout[SRC_SAFETY] = cfg.safe_timeout;
		// modular age against each source timeout
		for (int i = 0; i < NUM_SRC; i++) begin
			to_w[i]  = {48'd0, timeout[i]};
			limit[i] = to_w[i][TIME_BITS-1:0];
			fresh[i] = ((now_t - stamp[i]) <= limit[i]);
		end
	end

	always_comb begin
		result = '0;

		if (!status.present[SRC_AUTOPILOT]) begin
			result.autopilot_code = CODE_MISSING;
		end else if (!fresh[SRC_AUTOPILOT]) begin
			result.autopilot_code = CODE_STALE;
		end else if (!status.ap_flags[AP_CONNECTED]) begin
			result.autopilot_code = CODE_DISCONNECTED;
		end else if (status.ap_flags[AP_FAILSAFE]) begin
			result.autopilot_code = CODE_FAILSAFE;
		end else begin
			result.autopilot_code = CODE_OK;
		end

		if (!status.present[SRC_ESTIMATOR]) begin
			result.estimator_code = CODE_MISSING;
		end else if (!fresh[SRC_ESTIMATOR]) begin
			result.estimator_code = CODE_STALE;
		end else begin
			result.estimator_code = CODE_OK;
		end

		for (int m = 0; m < NUM_MGR; m++) begin
			if (!status.present[SRC_MGR_BASE + m]) begin
				mgr_code[m] = CODE_MISSING;
			end else if (!fresh[SRC_MGR_BASE + m]) begin
				mgr_code[m] = CODE_STALE;
			end else if (!status.mgr_active[m]) begin
				mgr_code[m] = CODE_INACTIVE;
			end else if (!status.mgr_healthy[m]) begin
				mgr_code[m] = CODE_UNHEALTHY;
			end else begin
				mgr_code[m] = CODE_OK;
			end
		end
		result.estimation_mgr_code = mgr_code[0];
		result.control_mgr_code    = mgr_code[1];
		result.trajectory_mgr_code = mgr_code[2];

		if (!status.present[SRC_SAFETY]) begin
			result.safety_code = CODE_MISSING;
		end else if (!fresh[SRC_SAFETY]) begin
			result.safety_code = CODE_STALE;
		end else if (status.safe_level >= SAFETY_CRITICAL) begin
			result.safety_code = CODE_UNHEALTHY;
		end else begin
			result.safety_code = CODE_OK;
		end

		// autopilot status is reported even when stale, zero when missing
		if (status.present[SRC_AUTOPILOT]) begin
			result.out_connected = status.ap_flags[AP_CONNECTED];
			result.out_armed     = status.ap_flags[AP_ARMED];
			result.out_offboard  = status.ap_flags[AP_OFFBOARD];
			result.out_nav_state = status.ap_nav;
		end
		result.out_require_safety = cfg.req_safety;
	end

endmodule

// ----- hw/rtl/heartbeat_health_monitor.sv -----
// top level: stream ports, timeout registers, input stage and result register
//
// Watchdog over six heartbeat sources (estimator stream, autopilot link, three
// managers, safety monitor). Items with cmd 0 to 5 store that source's time and
// status and give no result; cmd 6 gives one result with a readiness code per
// source; cmd 7 is dropped. One item per clock flows unless a query is held: an
// item passes the input stage, where updates are written and a query's six age
// checks are evaluated, and a query's result is in the output register on the
// next cycle. Updates flow while a result waits on m_tready; a query waits in
// the input stage only while the output register is full and stalled. Timeouts
// and the safety flag must be written over the cfg port while idle; unenforced.
module heartbeat_health_monitor #(
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// now_ms[31:0], active, healthy, connected, armed, offboard, failsafe,
	// nav_state[7:0], safety_level[7:0], zero pad
	input  logic [55:0] s_tdata,
	// cmd[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// autopilot_code[2:0], estimator_code[2:0], estimation_mgr_code[2:0],
	// control_mgr_code[2:0], trajectory_mgr_code[2:0], safety_code[2:0],
	// out_connected, out_armed, out_offboard, out_nav_state[7:0],
	// out_require_safety, zero pad
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import hhm_pkg::*;

	hhm_cfg_t             cfg_q;
	hhm_item_t            item_in;
	hhm_item_t            item_s1;
	logic                 valid_s1;
	logic                 query_s1;
	logic                 advance_s1;
	logic                 load_out;
	hhm_status_t          status;
	logic [TIME_BITS-1:0] stamp [NUM_SRC];
	hhm_result_t          result;
	hhm_result_t          result_q;
	logic                 out_valid_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.est_timeout  <= 16'd500;
			cfg_q.ap_timeout   <= 16'd500;
			cfg_q.mgr_timeout  <= 16'd500;
			cfg_q.safe_timeout <= 16'd500;
			cfg_q.req_safety   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EST_TIMEOUT:  cfg_q.est_timeout  <= cfg_data;
				REG_AP_TIMEOUT:   cfg_q.ap_timeout   <= cfg_data;
				REG_MGR_TIMEOUT:  cfg_q.mgr_timeout  <= cfg_data;
				REG_SAFE_TIMEOUT: cfg_q.safe_timeout <= cfg_data;
				REG_REQ_SAFETY:   cfg_q.req_safety   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// input item unpacking
	always_comb begin
		item_in.cmd          = s_tuser;
		item_in.now_ms       = s_tdata[31:0];
		item_in.active       = s_tdata[32];
		item_in.healthy      = s_tdata[33];
		item_in.connected    = s_tdata[34];
		item_in.armed        = s_tdata[35];
		item_in.offboard     = s_tdata[36];
		item_in.failsafe     = s_tdata[37];
		item_in.nav_state    = s_tdata[45:38];
		item_in.safety_level = s_tdata[53:46];
	end

	// input stage
	assign query_s1   = (item_s1.cmd == CMD_QUERY);
	assign advance_s1 = valid_s1 && (!query_s1 || !out_valid_q || m_tready);
	assign load_out   = advance_s1 && query_s1;
	assign s_tready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

	hhm_state #(
		.TIME_BITS(TIME_BITS)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.upd_en (advance_s1),
		.item   (item_s1),
		.status (status),
		.stamp  (stamp)
	);

	hhm_eval #(
		.TIME_BITS(TIME_BITS)
	) u_eval (
		.now_ms (item_s1.now_ms),
		.cfg    (cfg_q),
		.status (status),
		.stamp  (stamp),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, result_q.out_require_safety, result_q.out_nav_state,
		result_q.out_offboard, result_q.out_armed, result_q.out_connected,
		result_q.safety_code, result_q.trajectory_mgr_code, result_q.control_mgr_code,
		result_q.estimation_mgr_code, result_q.estimator_code, result_q.autopilot_code};

	a_query_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> m_tvalid)
		else $error("query left input stage without a result");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && !load_out) |=> !m_tvalid)
		else $error("result appeared without a query");

	a_update_never_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !query_s1) |-> s_tready)
		else $error("non-query item stalled the input");

	a_held_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> $stable(result_q))
		else $error("pending result overwritten");

endmodule
